// ----- rtl/core/lcd_mlt_pkg.sv -----
// shared types and constants for the lcd mode and line timer
// no dependencies

package lcd_mlt_pkg;

    // phase codes, equal to the lcd mode reported on the result channel
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_DRAW   = 2'd3
    } phase_t;

    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned LEN_W       = 10;
    localparam int unsigned ACC_W       = 16;
    localparam int unsigned LINE_W      = 8;
    localparam int unsigned ELAPSED_W   = 8;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COMPARE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HBLANK_IRQ_EN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_IRQ_EN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_CYCLES   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DRAW_CYCLES   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HBLANK_CYCLES = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_VBLANK_CYCLES = 3'd6;

    // reset lengths of the phases
    localparam logic [LEN_W-1:0] SCAN_CYCLES_RST   = 10'd80;
    localparam logic [LEN_W-1:0] DRAW_CYCLES_RST   = 10'd172;
    localparam logic [LEN_W-1:0] HBLANK_CYCLES_RST = 10'd204;
    localparam logic [LEN_W-1:0] VBLANK_CYCLES_RST = 10'd456;

    // frame geometry
    localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
    localparam logic [LINE_W-1:0] LAST_LINE     = 8'd153;

    typedef struct packed {
        logic [LINE_W-1:0] line_compare;
        logic              hblank_irq_enable;
        logic              compare_irq_enable;
        logic [LEN_W-1:0]  scan_phase_cycles;
        logic [LEN_W-1:0]  draw_phase_cycles;
        logic [LEN_W-1:0]  hblank_phase_cycles;
        logic [LEN_W-1:0]  vblank_line_cycles;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [ACC_W-1:0]  cycle_accumulator;
        logic [LINE_W-1:0] line_counter;
        logic              frame_ready_flag;
        logic              coincidence_bit;
    } state_t;

    typedef struct packed {
        logic [1:0]        lcd_mode;
        logic [LINE_W-1:0] current_line;
        logic              render_pulse;
        logic [LINE_W-1:0] rendered_line;
        logic              lcd_irq;
        logic              vblank_irq;
        logic              coincidence_flag;
        logic              frame_ready;
    } result_t;

endpackage

// ----- rtl/core/lcd_mlt_in_if.sv -----
// input channel: valid/ready handshake carrying the elapsed cycle count
// no dependencies

interface lcd_mlt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] elapsed_cycles;

    modport source (output valid, output elapsed_cycles, input ready);
    modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

// ----- rtl/core/lcd_mlt_out_if.sv -----
// result channel: valid/ready handshake carrying mode, line and interrupt pulses
// no dependencies

interface lcd_mlt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] lcd_mode;
    logic [7:0] current_line;
    logic       render_pulse;
    logic [7:0] rendered_line;
    logic       lcd_irq;
    logic       vblank_irq;
    logic       coincidence_flag;
    logic       frame_ready;

    modport source (
        output valid, output lcd_mode, output current_line, output render_pulse,
        output rendered_line, output lcd_irq, output vblank_irq,
        output coincidence_flag, output frame_ready, input ready
    );
    modport sink (
        input valid, input lcd_mode, input current_line, input render_pulse,
        input rendered_line, input lcd_irq, input vblank_irq,
        input coincidence_flag, input frame_ready, output ready
    );
endinterface

// ----- rtl/core/lcd_mlt_step.sv -----
// next-state and result logic for one transfer of the lcd mode and line timer
// depends on lcd_mlt_pkg

module lcd_mlt_step
    import lcd_mlt_pkg::*;
(
    input  cfg_t                 cfg,
    input  state_t               state,
    input  logic [ELAPSED_W-1:0] elapsed_cycles,
    output state_t               state_next,
    output result_t              result
);

    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;
    logic [LEN_W-1:0]  need;
    logic              take;
    logic [ACC_W-1:0]  acc_left;
    logic [LINE_W-1:0] line_inc;
    logic              coinc;

    // saturating accumulate, then the length of the current phase
    assign acc_sum = {1'b0, state.cycle_accumulator} + (ACC_W + 1)'(elapsed_cycles);
    assign acc_sat = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];

    always_comb
    begin
        case (state.phase)
            MODE_SCAN:   need = cfg.scan_phase_cycles;
            MODE_DRAW:   need = cfg.draw_phase_cycles;
            MODE_HBLANK: need = cfg.hblank_phase_cycles;
            default:     need = cfg.vblank_line_cycles;
        endcase
    end

    assign take     = acc_sat >= ACC_W'(need);
    assign acc_left = take ? (acc_sat - ACC_W'(need)) : acc_sat;
    assign line_inc = state.line_counter + 8'd1;
    assign coinc    = (state.line_counter == cfg.line_compare);

    always_comb
    begin
        state_next                   = state;
        state_next.cycle_accumulator = acc_left;
        result                       = '0;

        case (state.phase)
            MODE_SCAN:
            begin
                if (take)
                begin
                    state_next.phase = MODE_DRAW;
                end
            end
            MODE_DRAW:
            begin
                if (take)
                begin
                    result.render_pulse        = 1'b1;
                    result.rendered_line       = state.line_counter;
                    state_next.line_counter    = line_inc;
                    state_next.phase           = MODE_HBLANK;
                    state_next.coincidence_bit = coinc;
                    result.lcd_irq = cfg.hblank_irq_enable | (coinc & cfg.compare_irq_enable);
                end
            end
            MODE_HBLANK:
            begin
                if (take)
                begin
                    if (state.line_counter == VISIBLE_LINES)
                    begin
                        state_next.frame_ready_flag = 1'b1;
                        state_next.phase            = MODE_VBLANK;
                        result.vblank_irq           = 1'b1;
                    end
                    else
                    begin
                        state_next.phase = MODE_SCAN;
                    end
                end
            end
            default:
            begin
                state_next.frame_ready_flag = 1'b0;
                if (take)
                begin
                    if (line_inc == LAST_LINE)
                    begin
                        state_next.line_counter = '0;
                        state_next.phase        = MODE_SCAN;
                    end
                    else
                    begin
                        state_next.line_counter = line_inc;
                    end
                end
            end
        endcase

        result.lcd_mode         = state_next.phase;
        result.current_line     = state_next.line_counter;
        result.coincidence_flag = state_next.coincidence_bit;
        result.frame_ready      = state_next.frame_ready_flag;
    end

endmodule

// ----- rtl/core/lcd_mlt_obuf.sv -----
// two-entry result buffer: output register plus skid register, registered ready
// depends on lcd_mlt_pkg

module lcd_mlt_obuf
    import lcd_mlt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_data_reg;
    result_t main_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    pop;

    assign pop        = main_valid_reg & out_ready;
    assign push_ready = ~skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- rtl/core/lcd_mode_line_timer.sv -----
// top level of the lcd mode and line timer: configuration registers, timing state
// depends on lcd_mlt_pkg, lcd_mlt_in_if, lcd_mlt_out_if, lcd_mlt_step, lcd_mlt_obuf

// Tracks the LCD controller's mode (OAM scan, drawing, horizontal blank,
// vertical blank) and the current line from a stream of elapsed machine-cycle
// counts. Every transfer on in_ch adds its count to a saturating 16-bit
// accumulator and makes at most one mode change; exactly one result transfer
// on out_ch follows, carrying the mode and line after the step plus the render,
// LCD-interrupt and vblank-interrupt pulses of that step. Throughput is one
// transfer per clock unless stalled: the step is one pass of combinational
// logic that updates the timing state at the input edge. Results queue in a
// two-entry buffer (output register plus skid register), so in_ch.ready stays
// high while a single result waits and only drops once two results are
// pending. Configuration is written through cfg_we/cfg_index/cfg_data while
// the block is idle (the user's duty, left unchecked); index values above 6
// are ignored. Phase lengths of zero make a phase end on every step.

module lcd_mode_line_timer
    import lcd_mlt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    lcd_mlt_in_if.sink             in_ch,
    lcd_mlt_out_if.source          out_ch
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    state_t  state_reg;
    state_t  state_next;
    state_t  step_state;
    result_t step_result;
    result_t out_data;
    logic    in_xfer;

    // an item is taken whenever the result buffer has a free slot
    assign in_xfer = in_ch.valid & in_ch.ready;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_COMPARE:   cfg_next.line_compare        = cfg_data[LINE_W-1:0];
                REG_HBLANK_IRQ_EN:  cfg_next.hblank_irq_enable   = cfg_data[0];
                REG_COMPARE_IRQ_EN: cfg_next.compare_irq_enable  = cfg_data[0];
                REG_SCAN_CYCLES:    cfg_next.scan_phase_cycles   = cfg_data[LEN_W-1:0];
                REG_DRAW_CYCLES:    cfg_next.draw_phase_cycles   = cfg_data[LEN_W-1:0];
                REG_HBLANK_CYCLES:  cfg_next.hblank_phase_cycles = cfg_data[LEN_W-1:0];
                REG_VBLANK_CYCLES:  cfg_next.vblank_line_cycles  = cfg_data[LEN_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_compare        <= '0;
            cfg_reg.hblank_irq_enable   <= 1'b0;
            cfg_reg.compare_irq_enable  <= 1'b0;
            cfg_reg.scan_phase_cycles   <= SCAN_CYCLES_RST;
            cfg_reg.draw_phase_cycles   <= DRAW_CYCLES_RST;
            cfg_reg.hblank_phase_cycles <= HBLANK_CYCLES_RST;
            cfg_reg.vblank_line_cycles  <= VBLANK_CYCLES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // one step of the mode/line timing per transfer
    lcd_mlt_step u_step (
        .cfg            (cfg_reg),
        .state          (state_reg),
        .elapsed_cycles (in_ch.elapsed_cycles),
        .state_next     (step_state),
        .result         (step_result)
    );

    // timing state only moves on an input transfer
    assign state_next = in_xfer ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase             <= MODE_SCAN;
            state_reg.cycle_accumulator <= '0;
            state_reg.line_counter      <= '0;
            state_reg.frame_ready_flag  <= 1'b0;
            state_reg.coincidence_bit   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result register and skid slot toward out_ch
    lcd_mlt_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_xfer),
        .push_data  (step_result),
        .push_ready (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_data   (out_data)
    );

    assign out_ch.lcd_mode         = out_data.lcd_mode;
    assign out_ch.current_line     = out_data.current_line;
    assign out_ch.render_pulse     = out_data.render_pulse;
    assign out_ch.rendered_line    = out_data.rendered_line;
    assign out_ch.lcd_irq          = out_data.lcd_irq;
    assign out_ch.vblank_irq       = out_data.vblank_irq;
    assign out_ch.coincidence_flag = out_data.coincidence_flag;
    assign out_ch.frame_ready      = out_data.frame_ready;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for lcd_mode_line_timer: directed table, then randomized phases
// depends on lcd_mlt_pkg, lcd_mlt_in_if, lcd_mlt_out_if and the timer rtl

module tb;
    import lcd_mlt_pkg::*;

    // unused slot of the register map, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int LONG_HOLD   = 64;
    localparam int DIR_ROWS    = 20;

    // shape of the elapsed-cycle draw
    localparam int BIAS_FULL = 0;
    localparam int BIAS_HIGH = 1;
    localparam int BIAS_LOW  = 2;

    typedef struct {
        logic [ELAPSED_W-1:0] elapsed;
        bit                   typed;
        result_t              want;
    } step_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    lcd_mlt_in_if  in_ch();
    lcd_mlt_out_if out_ch();

    lcd_mode_line_timer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #5 clk = ~clk;

    // timing state mirrored by the bench
    cfg_t             tm_cfg;
    phase_t           tm_phase;
    logic [ACC_W-1:0] tm_acc;
    logic [LINE_W-1:0] tm_line;
    logic             tm_frame_ready;
    logic             tm_coinc;

    // expected results, oldest first
    result_t expected_timing [$];

    // directed rows may carry a hand-written result instead of the mirrored one
    bit      typed_pending = 1'b0;
    result_t typed_result;

    bit long_hold_req = 1'b0;

    int error_count    = 0;
    int items_in       = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int lines_drawn    = 0;
    int frames_seen    = 0;
    int lcd_irqs_seen  = 0;
    int coincidences   = 0;
    int cycle_count    = 0;

    function automatic void reset_timing_state();
        tm_cfg.line_compare        = '0;
        tm_cfg.hblank_irq_enable   = 1'b0;
        tm_cfg.compare_irq_enable  = 1'b0;
        tm_cfg.scan_phase_cycles   = SCAN_CYCLES_RST;
        tm_cfg.draw_phase_cycles   = DRAW_CYCLES_RST;
        tm_cfg.hblank_phase_cycles = HBLANK_CYCLES_RST;
        tm_cfg.vblank_line_cycles  = VBLANK_CYCLES_RST;
        tm_phase       = MODE_SCAN;
        tm_acc         = '0;
        tm_line        = '0;
        tm_frame_ready = 1'b0;
        tm_coinc       = 1'b0;
    endfunction

    function automatic void apply_timing_reg(logic [CFG_INDEX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_LINE_COMPARE:   tm_cfg.line_compare        = value[LINE_W-1:0];
            REG_HBLANK_IRQ_EN:  tm_cfg.hblank_irq_enable   = value[0];
            REG_COMPARE_IRQ_EN: tm_cfg.compare_irq_enable  = value[0];
            REG_SCAN_CYCLES:    tm_cfg.scan_phase_cycles   = value[LEN_W-1:0];
            REG_DRAW_CYCLES:    tm_cfg.draw_phase_cycles   = value[LEN_W-1:0];
            REG_HBLANK_CYCLES:  tm_cfg.hblank_phase_cycles = value[LEN_W-1:0];
            REG_VBLANK_CYCLES:  tm_cfg.vblank_line_cycles  = value[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    // a phase ends only when the accumulator covers its length; a zero length always does
    function automatic bit consume_cycles(logic [LEN_W-1:0] len);
        if (tm_acc < ACC_W'(len))
            return 1'b0;
        tm_acc = tm_acc - ACC_W'(len);
        return 1'b1;
    endfunction

    // one item: add the count, then at most one phase change
    function automatic result_t advance_timing(logic [ELAPSED_W-1:0] elapsed);
        result_t        res;
        logic [ACC_W:0] sum;
        res = '0;
        sum = {1'b0, tm_acc} + (ACC_W+1)'(elapsed);
        tm_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];   // saturate at full scale
        case (tm_phase)
            MODE_SCAN:
                if (consume_cycles(tm_cfg.scan_phase_cycles))
                    tm_phase = MODE_DRAW;
            MODE_DRAW:
                if (consume_cycles(tm_cfg.draw_phase_cycles))
                begin
                    res.render_pulse  = 1'b1;
                    res.rendered_line = tm_line;
                    tm_line  = tm_line + 1'b1;
                    tm_phase = MODE_HBLANK;
                    tm_coinc = (res.rendered_line == tm_cfg.line_compare);
                    res.lcd_irq = tm_cfg.hblank_irq_enable
                                | (tm_coinc & tm_cfg.compare_irq_enable);
                end
            MODE_HBLANK:
                if (consume_cycles(tm_cfg.hblank_phase_cycles))
                begin
                    if (tm_line == VISIBLE_LINES)
                    begin
                        tm_frame_ready = 1'b1;
                        tm_phase       = MODE_VBLANK;
                        res.vblank_irq = 1'b1;
                    end
                    else
                    begin
                        tm_phase = MODE_SCAN;
                    end
                end
            default:
            begin
                // any vblank step drops frame ready, advancing or not
                tm_frame_ready = 1'b0;
                if (consume_cycles(tm_cfg.vblank_line_cycles))
                begin
                    tm_line = tm_line + 1'b1;
                    if (tm_line == LAST_LINE)
                    begin
                        tm_line  = '0;
                        tm_phase = MODE_SCAN;
                    end
                end
            end
        endcase
        res.lcd_mode         = tm_phase;
        res.current_line     = tm_line;
        res.coincidence_flag = tm_coinc;
        res.frame_ready      = tm_frame_ready;
        return res;
    endfunction

    function automatic result_t mk_result(phase_t mode, int line, bit render, int drawn,
                                          bit lcd_irq, bit vb_irq, bit coinc, bit frame);
        result_t res;
        res.lcd_mode         = mode;
        res.current_line     = LINE_W'(line);
        res.render_pulse     = render;
        res.rendered_line    = LINE_W'(drawn);
        res.lcd_irq          = lcd_irq;
        res.vblank_irq       = vb_irq;
        res.coincidence_flag = coinc;
        res.frame_ready      = frame;
        return res;
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_elapsed(int bias);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        if (bias == BIAS_HIGH && roll < 7)
            return 8'hFF;
        if (bias == BIAS_LOW && roll < 7)
            return ELAPSED_W'($urandom_range(0, 15));
        return ELAPSED_W'($urandom_range(0, 255));
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got)
            report_error($sformatf("result %0d %s expected %0d got %0d",
                                   results_seen, fname, want, got));
    endtask

    // ------------------------------------------------------------------
    // scoreboard: at each edge first record the input transfer, then check
    // the output transfer; the result register keeps these apart anyway
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : timing_check
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                want = advance_timing(in_ch.elapsed_cycles);
                if (typed_pending)
                    want = typed_result;
                expected_timing.push_back(want);
                items_in++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.lcd_mode         = out_ch.lcd_mode;
                got.current_line     = out_ch.current_line;
                got.render_pulse     = out_ch.render_pulse;
                got.rendered_line    = out_ch.rendered_line;
                got.lcd_irq          = out_ch.lcd_irq;
                got.vblank_irq       = out_ch.vblank_irq;
                got.coincidence_flag = out_ch.coincidence_flag;
                got.frame_ready      = out_ch.frame_ready;
                if (expected_timing.size() == 0)
                begin
                    report_error($sformatf("result %0d arrived with nothing outstanding",
                                           results_seen));
                end
                else
                begin
                    want = expected_timing.pop_front();
                    check_field("lcd_mode", want.lcd_mode, got.lcd_mode);
                    check_field("current_line", want.current_line, got.current_line);
                    check_field("render_pulse", want.render_pulse, got.render_pulse);
                    check_field("rendered_line", want.rendered_line, got.rendered_line);
                    check_field("lcd_irq", want.lcd_irq, got.lcd_irq);
                    check_field("vblank_irq", want.vblank_irq, got.vblank_irq);
                    check_field("coincidence_flag", want.coincidence_flag,
                                got.coincidence_flag);
                    check_field("frame_ready", want.frame_ready, got.frame_ready);
                end
                results_seen++;
                if (got.render_pulse)
                    lines_drawn++;
                if (got.vblank_irq)
                    frames_seen++;
                if (got.lcd_irq)
                    lcd_irqs_seen++;
                if (got.render_pulse && got.coincidence_flag)
                    coincidences++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_timing.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result side: random stalls, quiet stretches, and a long hold-off on each
    // request so the skid buffer fills and input ready drops
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        int taken;
        out_ch.ready = 1'b0;
        taken = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                stall = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if ((taken % 160) < 40)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, 7);
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            taken++;
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // input side and configuration; every task starts and ends on a
    // falling edge
    // ------------------------------------------------------------------

    // leaves the write enable high so back-to-back writes need no toggling
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        apply_timing_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic configure_timer(logic [7:0] cmp, bit hb_en, bit cmp_en,
                                   logic [9:0] scan, logic [9:0] draw,
                                   logic [9:0] hbl, logic [9:0] vbl);
        write_reg(REG_LINE_COMPARE, CFG_DATA_W'(cmp));
        write_reg(REG_HBLANK_IRQ_EN, CFG_DATA_W'(hb_en));
        write_reg(REG_COMPARE_IRQ_EN, CFG_DATA_W'(cmp_en));
        write_reg(REG_SCAN_CYCLES, scan);
        write_reg(REG_DRAW_CYCLES, draw);
        write_reg(REG_HBLANK_CYCLES, hbl);
        write_reg(REG_VBLANK_CYCLES, vbl);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // valid stays up across items when no gap is drawn
    task automatic drive_item(logic [ELAPSED_W-1:0] elapsed);
        int gap;
        gap = ((items_sent % 200) < 40) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.elapsed_cycles <= elapsed;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // block is idle once every transfer has come back; one result per item
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_timing.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_phase(logic [7:0] cmp, bit hb_en, bit cmp_en,
                             logic [9:0] scan, logic [9:0] draw,
                             logic [9:0] hbl, logic [9:0] vbl, int count, int bias);
        configure_timer(cmp, hb_en, cmp_en, scan, draw, hbl, vbl);
        for (int k = 0; k < count; k++)
            drive_item(pick_elapsed(bias));
        drain_results();
    endtask

    initial
    begin : stimulus
        step_row_t steps [DIR_ROWS];
        int        n;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.elapsed_cycles = '0;
        reset_timing_state();

        // directed table, reset lengths 80/172/204/456, compare 0, irqs off;
        // the first rows are short enough to follow by hand
        steps[0]  = '{8'd0,   1'b1, mk_result(MODE_SCAN, 0, 0, 0, 0, 0, 0, 0)};
        steps[1]  = '{8'd79,  1'b1, mk_result(MODE_SCAN, 0, 0, 0, 0, 0, 0, 0)};
        steps[2]  = '{8'd1,   1'b1, mk_result(MODE_DRAW, 0, 0, 0, 0, 0, 0, 0)};
        steps[3]  = '{8'd255, 1'b1, mk_result(MODE_HBLANK, 1, 1, 0, 0, 0, 1, 0)};
        steps[4]  = '{8'd255, 1'b1, mk_result(MODE_SCAN, 1, 0, 0, 0, 0, 1, 0)};
        steps[5]  = '{8'd255, 1'b0, '0};
        steps[6]  = '{8'd255, 1'b0, '0};
        steps[7]  = '{8'd128, 1'b0, '0};
        steps[8]  = '{8'd1,   1'b0, '0};
        steps[9]  = '{8'd0,   1'b0, '0};
        steps[10] = '{8'd200, 1'b0, '0};
        steps[11] = '{8'd172, 1'b0, '0};
        steps[12] = '{8'd3,   1'b0, '0};
        steps[13] = '{8'd255, 1'b0, '0};
        steps[14] = '{8'd85,  1'b0, '0};
        steps[15] = '{8'd170, 1'b0, '0};
        steps[16] = '{8'd254, 1'b0, '0};
        steps[17] = '{8'd127, 1'b0, '0};
        steps[18] = '{8'd128, 1'b0, '0};
        steps[19] = '{8'd255, 1'b0, '0};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unmapped index with all ones: nothing may change, the typed rows show it
        write_reg(REG_UNUSED, '1);
        cfg_we <= 1'b0;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            typed_pending = steps[r].typed;
            typed_result  = steps[r].want;
            drive_item(steps[r].elapsed);
        end
        typed_pending = 1'b0;
        drain_results();

        // longest lengths everywhere, compare never hits a drawn line
        run_phase(8'd255, 1'b1, 1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                  150, BIAS_FULL);

        // unit lengths with mostly full counts: accumulator saturates and a
        // whole frame runs; the long hold-off lands here
        long_hold_req = 1'b1;
        run_phase(8'd0, 1'b0, 1'b1, 10'd1, 10'd1, 10'd1, 10'd1, 480, BIAS_HIGH);

        // zero lengths: every step leaves its phase without subtracting
        run_phase(8'd143, 1'b1, 1'b0, 10'd0, 10'd0, 10'd0, 10'd0, 460, BIAS_FULL);

        // short random lengths and random compare/irq settings
        for (int p = 0; p < 2; p++)
        begin
            n = 225;
            if (p == 1)
                long_hold_req = 1'b1;
            run_phase(8'($urandom_range(0, 143)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)),
                      10'($urandom_range(1, 24)), 10'($urandom_range(1, 24)),
                      10'($urandom_range(1, 24)), 10'($urandom_range(1, 24)),
                      n, BIAS_LOW);
        end

        // back to the reset lengths with both interrupt sources on
        run_phase(8'($urandom_range(0, 143)), 1'b1, 1'b1, SCAN_CYCLES_RST, DRAW_CYCLES_RST,
                  HBLANK_CYCLES_RST, VBLANK_CYCLES_RST, 150, BIAS_FULL);

        repeat (4) @(posedge clk);
        if (expected_timing.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_timing.size()));

        $display("run covered %0d input transfers, %0d results, %0d lines drawn, %0d frames",
                 items_in, results_seen, lines_drawn, frames_seen);
        $display("lcd interrupts %0d, coincident lines %0d, mismatches %0d",
                 lcd_irqs_seen, coincidences, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/lcd_mlt_pkg.sv
rtl/core/lcd_mlt_in_if.sv
rtl/core/lcd_mlt_out_if.sv
rtl/core/lcd_mlt_step.sv
rtl/core/lcd_mlt_obuf.sv
rtl/core/lcd_mode_line_timer.sv
tb/tb.sv
